>>> rtl/core/ssc_pkg.sv
// types, constants and widths shared by the slot statistics counter bank
`timescale 1ns / 1ps

package ssc_pkg;

   localparam int MAX_SLOTS = 16;
   localparam int SLOT_AW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CMD_W     = 3;
   localparam int SLOT_W    = 8;
   localparam int DATA_W    = 32;
   localparam int CAP_W     = 5;
   localparam int USED_W    = 5;
   localparam int DIV_CNT_W = $clog2(DATA_W);
   localparam int MEM_W     = 3 * DATA_W;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   localparam logic MODE_COUNTER = 1'b0;
   localparam logic MODE_SAMPLE  = 1'b1;

   typedef enum logic [CMD_W-1:0] {
      CMD_RECORD_COUNTER = 3'd0,
      CMD_RECORD_SAMPLE  = 3'd1,
      CMD_SET_MODE       = 3'd2,
      CMD_QUERY          = 3'd3,
      CMD_CLEAR          = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_UPDATE,
      S_DIV,
      S_DONE
   } state_type;

   typedef struct packed {
      logic              slot_valid;
      logic              slot_used;
      logic              slot_mode;
      logic [DATA_W-1:0] sum_value;
      logic [DATA_W-1:0] sample_count;
      logic [DATA_W-1:0] max_amount;
      logic [DATA_W-1:0] average_value;
      logic [USED_W-1:0] used_count;
      logic              any_data;
   } rsp_payload_type;

endpackage

>>> rtl/core/ssc_req_if.sv
// request channel of the slot statistics counter bank
`timescale 1ns / 1ps

interface ssc_req_if;
   logic                        valid;
   logic                        ready;
   logic [ssc_pkg::CMD_W-1:0]   cmd;
   logic [ssc_pkg::SLOT_W-1:0]  slot;
   logic [ssc_pkg::DATA_W-1:0]  amount;
   logic                        mode_in;

   modport source (output valid, output cmd, output slot, output amount, output mode_in,
                   input ready);
   modport sink (input valid, input cmd, input slot, input amount, input mode_in,
                 output ready);
endinterface

>>> rtl/core/ssc_rsp_if.sv
// response channel of the slot statistics counter bank
`timescale 1ns / 1ps

interface ssc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        slot_valid;
   logic                        slot_used;
   logic                        slot_mode;
   logic [ssc_pkg::DATA_W-1:0]  sum_value;
   logic [ssc_pkg::DATA_W-1:0]  sample_count;
   logic [ssc_pkg::DATA_W-1:0]  max_amount;
   logic [ssc_pkg::DATA_W-1:0]  average_value;
   logic [ssc_pkg::USED_W-1:0]  used_count;
   logic                        any_data;

   modport source (output valid, output slot_valid, output slot_used, output slot_mode,
                   output sum_value, output sample_count, output max_amount,
                   output average_value, output used_count, output any_data,
                   input ready);
   modport sink (input valid, input slot_valid, input slot_used, input slot_mode,
                 input sum_value, input sample_count, input max_amount,
                 input average_value, input used_count, input any_data,
                 output ready);
endinterface

>>> rtl/core/slot_statistics_counter_bank.sv
// slot statistics counter bank: per-slot sums, counts, maxima and averages
// One request is handled at a time. A request is taken in one cycle, the slot
// is read from the statistics memory and updated in the next, and the average
// then comes from a shared restoring divider that produces one quotient bit per
// cycle; the response is then loaded into the output register once that register
// is empty or its response is being taken. The divider runs only when the slot is
// valid and its count is nonzero, and a new request is taken in the cycle after
// the response is loaded, while that response may still wait to be taken. The
// clear command zeroes all slots below the capacity, and the store is empty
// straight after reset with no clearing pass.
`timescale 1ns / 1ps

module slot_statistics_counter_bank (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [ssc_pkg::CAP_W-1:0]    csr_wdata,
   ssc_req_if.sink                      req_ch,
   ssc_rsp_if.source                    rsp_ch
);

   ssc_pkg::state_type                 state_ff, state_in;
   logic [ssc_pkg::CAP_W-1:0]          cap_ff;

   logic [ssc_pkg::MAX_SLOTS-1:0]      used_ff, used_in;
   logic [ssc_pkg::MAX_SLOTS-1:0]      slot_mode_ff, slot_mode_in;
   logic [ssc_pkg::MAX_SLOTS-1:0]      live_ff, live_in;
   logic [ssc_pkg::MAX_SLOTS-1:0]      nz_ff, nz_in;
   logic [ssc_pkg::USED_W-1:0]         used_total_ff, used_total_in;

   ssc_pkg::cmd_type                   cmd_ff, cmd_in;
   logic [ssc_pkg::SLOT_W-1:0]         slot_ff, slot_in;
   logic [ssc_pkg::DATA_W-1:0]         amount_ff, amount_in;
   logic                               req_mode_ff, req_mode_in;
   logic                               valid_ff, valid_in;

   logic [ssc_pkg::DATA_W-1:0]         sum_ff, sum_in;
   logic [ssc_pkg::DATA_W-1:0]         cnt_ff, cnt_in;
   logic [ssc_pkg::DATA_W-1:0]         max_ff, max_in;
   logic [ssc_pkg::DATA_W-1:0]         rem_ff, rem_in;
   logic [ssc_pkg::DATA_W-1:0]         quo_ff, quo_in;
   logic [ssc_pkg::DIV_CNT_W-1:0]      div_cnt_ff, div_cnt_in;

   ssc_pkg::rsp_payload_type           out_ff, out_in;
   logic                               out_valid_ff, out_valid_in;

   logic [ssc_pkg::MEM_W-1:0]          stat_mem [ssc_pkg::MAX_SLOTS];
   logic [ssc_pkg::MEM_W-1:0]          rd_data_ff;
   logic [ssc_pkg::SLOT_AW-1:0]        rd_addr;
   logic [ssc_pkg::SLOT_AW-1:0]        slot_idx;
   logic                               mem_we;
   logic [ssc_pkg::MEM_W-1:0]          mem_wdata;

   logic [ssc_pkg::SLOT_W-1:0]         cap_ext;
   logic [ssc_pkg::SLOT_W-1:0]         eff_cap;
   logic [ssc_pkg::MAX_SLOTS-1:0]      cap_mask;
   logic                               any_data_w;
   logic                               mark_slot;

   logic [ssc_pkg::DATA_W-1:0]         cur_sum, cur_cnt, cur_max;
   logic [ssc_pkg::DATA_W-1:0]         rec_sum, rec_cnt, rec_max;
   logic [ssc_pkg::DATA_W:0]           div_sh, div_diff;

   // capacity and slot addressing
   assign cap_ext  = ssc_pkg::SLOT_W'(cap_ff);
   assign eff_cap  = (cap_ext > ssc_pkg::SLOT_W'(ssc_pkg::MAX_SLOTS)) ?
                     ssc_pkg::SLOT_W'(ssc_pkg::MAX_SLOTS) : cap_ext;
   assign slot_idx = slot_ff[ssc_pkg::SLOT_AW-1:0];
   assign rd_addr  = req_ch.slot[ssc_pkg::SLOT_AW-1:0];

   always_comb begin
      for (int i = 0; i < ssc_pkg::MAX_SLOTS; i++) begin
         cap_mask[i] = ssc_pkg::SLOT_W'(i) < eff_cap;
      end
   end

   assign any_data_w = |(used_ff & live_ff & nz_ff & cap_mask);

   // slot data as stored, an entry not live since the last clear reads as zero
   assign cur_sum = live_ff[slot_idx] ?
                    rd_data_ff[ssc_pkg::MEM_W-1 -: ssc_pkg::DATA_W] : '0;
   assign cur_cnt = live_ff[slot_idx] ?
                    rd_data_ff[2*ssc_pkg::DATA_W-1 -: ssc_pkg::DATA_W] : '0;
   assign cur_max = live_ff[slot_idx] ? rd_data_ff[ssc_pkg::DATA_W-1:0] : '0;

   assign rec_sum   = cur_sum + amount_ff;
   assign rec_cnt   = cur_cnt + ssc_pkg::DATA_W'(1);
   assign rec_max   = (amount_ff > cur_max) ? amount_ff : cur_max;
   assign mem_wdata = {rec_sum, rec_cnt, rec_max};

   // shared restoring divider step
   assign div_sh   = {rem_ff, quo_ff[ssc_pkg::DATA_W-1]};
   assign div_diff = div_sh - {1'b0, cnt_ff};

   assign req_ch.ready         = (state_ff == ssc_pkg::S_IDLE);
   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.slot_valid    = out_ff.slot_valid;
   assign rsp_ch.slot_used     = out_ff.slot_used;
   assign rsp_ch.slot_mode     = out_ff.slot_mode;
   assign rsp_ch.sum_value     = out_ff.sum_value;
   assign rsp_ch.sample_count  = out_ff.sample_count;
   assign rsp_ch.max_amount    = out_ff.max_amount;
   assign rsp_ch.average_value = out_ff.average_value;
   assign rsp_ch.used_count    = out_ff.used_count;
   assign rsp_ch.any_data      = out_ff.any_data;

   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      slot_mode_in  = slot_mode_ff;
      live_in       = live_ff;
      nz_in         = nz_ff;
      used_total_in = used_total_ff;
      cmd_in        = cmd_ff;
      slot_in       = slot_ff;
      amount_in     = amount_ff;
      req_mode_in   = req_mode_ff;
      valid_in      = valid_ff;
      sum_in        = sum_ff;
      cnt_in        = cnt_ff;
      max_in        = max_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      div_cnt_in    = div_cnt_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      mem_we        = 1'b0;
      mark_slot     = 1'b0;

      if (rsp_ch.valid && rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ssc_pkg::S_IDLE: begin
            if (req_ch.valid) begin
               cmd_in      = ssc_pkg::cmd_type'(req_ch.cmd);
               slot_in     = req_ch.slot;
               amount_in   = req_ch.amount;
               req_mode_in = req_ch.mode_in;
               valid_in    = req_ch.slot < eff_cap;
               state_in    = ssc_pkg::S_UPDATE;
            end
         end
         ssc_pkg::S_UPDATE: begin
            sum_in = cur_sum;
            cnt_in = cur_cnt;
            max_in = cur_max;
            case (cmd_ff)
               ssc_pkg::CMD_RECORD_COUNTER, ssc_pkg::CMD_RECORD_SAMPLE: begin
                  if (valid_ff) begin
                     mem_we                 = 1'b1;
                     sum_in                 = rec_sum;
                     cnt_in                 = rec_cnt;
                     max_in                 = rec_max;
                     live_in[slot_idx]      = 1'b1;
                     nz_in[slot_idx]        = |mem_wdata;
                     slot_mode_in[slot_idx] = (cmd_ff == ssc_pkg::CMD_RECORD_SAMPLE) ?
                                              ssc_pkg::MODE_SAMPLE : ssc_pkg::MODE_COUNTER;
                     mark_slot              = 1'b1;
                  end
               end
               ssc_pkg::CMD_SET_MODE: begin
                  if (valid_ff) begin
                     slot_mode_in[slot_idx] = req_mode_ff;
                     mark_slot              = 1'b1;
                  end
               end
               ssc_pkg::CMD_CLEAR: begin
                  live_in = live_ff & ~cap_mask;
                  sum_in  = '0;
                  cnt_in  = '0;
                  max_in  = '0;
               end
               default: begin
               end
            endcase
            if (mark_slot && !used_ff[slot_idx]) begin
               used_in[slot_idx] = 1'b1;
               if (used_total_ff != '1) begin
                  used_total_in = used_total_ff + ssc_pkg::USED_W'(1);
               end
            end
            if (!valid_ff) begin
               sum_in = '0;
               cnt_in = '0;
               max_in = '0;
            end
            rem_in     = '0;
            quo_in     = sum_in;
            div_cnt_in = '0;
            if (cnt_in == '0) begin
               quo_in   = '0;
               state_in = ssc_pkg::S_DONE;
            end else begin
               state_in = ssc_pkg::S_DIV;
            end
         end
         ssc_pkg::S_DIV: begin
            if (!div_diff[ssc_pkg::DATA_W]) begin
               rem_in = div_diff[ssc_pkg::DATA_W-1:0];
            end else begin
               rem_in = div_sh[ssc_pkg::DATA_W-1:0];
            end
            quo_in     = {quo_ff[ssc_pkg::DATA_W-2:0], ~div_diff[ssc_pkg::DATA_W]};
            div_cnt_in = div_cnt_ff + ssc_pkg::DIV_CNT_W'(1);
            if (div_cnt_ff == ssc_pkg::DIV_CNT_W'(ssc_pkg::DATA_W - 1)) begin
               state_in = ssc_pkg::S_DONE;
            end
         end
         ssc_pkg::S_DONE: begin
            if (!out_valid_ff || rsp_ch.ready) begin
               out_in.slot_valid    = valid_ff;
               out_in.slot_used     = valid_ff & used_ff[slot_idx];
               out_in.slot_mode     = valid_ff & slot_mode_ff[slot_idx];
               out_in.sum_value     = sum_ff;
               out_in.sample_count  = cnt_ff;
               out_in.max_amount    = max_ff;
               out_in.average_value = quo_ff;
               out_in.used_count    = used_total_ff;
               out_in.any_data      = any_data_w;
               out_valid_in         = 1'b1;
               state_in             = ssc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ssc_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssc_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff        <= ssc_pkg::CAP_RESET;
         used_ff       <= '0;
         slot_mode_ff  <= '0;
         live_ff       <= '0;
         used_total_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
         used_ff       <= used_in;
         slot_mode_ff  <= slot_mode_in;
         live_ff       <= live_in;
         used_total_ff <= used_total_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nz_ff       <= nz_in;
      cmd_ff      <= cmd_in;
      slot_ff     <= slot_in;
      amount_ff   <= amount_in;
      req_mode_ff <= req_mode_in;
      valid_ff    <= valid_in;
      sum_ff      <= sum_in;
      cnt_ff      <= cnt_in;
      max_ff      <= max_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      div_cnt_ff  <= div_cnt_in;
      out_ff      <= out_in;
   end

   // statistics memory: sum, count and maximum of each slot
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stat_mem[slot_idx] <= mem_wdata;
      end
      rd_data_ff <= stat_mem[rd_addr];
   end

   a_used_total: assert property (@(posedge clock) disable iff (reset)
      (used_total_ff == ssc_pkg::USED_W'($countones(used_ff))) || (used_total_ff == '1))
      else $error("used slot total out of step with used marks");

   a_accept_update: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff == ssc_pkg::S_UPDATE))
      else $error("accepted request not followed by slot update");

   a_div_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ssc_pkg::S_DIV &&
       div_cnt_ff == ssc_pkg::DIV_CNT_W'(ssc_pkg::DATA_W - 1)) |=>
      (state_ff == ssc_pkg::S_DONE))
      else $error("divider overran its last step");

   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == ssc_pkg::S_DONE))
      else $error("response loaded outside the done state");

   a_mem_write: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (valid_ff && state_ff == ssc_pkg::S_UPDATE))
      else $error("statistics write for an invalid slot");

endmodule
